// ===== rtl/core/mtg_pkg.sv =====
// Shared types, constants and helper functions for the MT19937 generator core.
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

    localparam int unsigned STATE_WORDS   = 624;
    localparam int unsigned MIDDLE_OFFSET = 397;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned WORD_W        = 32;

    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0]  FULL_IDX     = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0]  UNSEEDED_IDX = IDX_W'(STATE_WORDS + 1);
    localparam logic [IDX_W:0]    WRAP_WORDS   = (IDX_W + 1)'(STATE_WORDS);
    localparam logic [IDX_W:0]    MID_STEP     = (IDX_W + 1)'(MIDDLE_OFFSET);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [16:0]       LCG_MULT     = 17'd69069;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_PRIME,
        ST_TWIST,
        ST_DRAW,
        ST_OUT
    } mtg_state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SEED,
        CMD_FILL,
        CMD_PRIME,
        CMD_TWIST,
        CMD_DRAW,
        CMD_OUT
    } mtg_op_t;

    typedef struct packed {
        mtg_op_t          op;
        logic [IDX_W-1:0] addr;
    } mtg_cmd_t;

    typedef struct packed {
        logic out_free;
    } mtg_status_t;

    function automatic logic [WORD_W-1:0] mtg_temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [WORD_W-1:0] mtg_twist(input logic [WORD_W-1:0] cur,
                                                    input logic [WORD_W-1:0] nxt,
                                                    input logic [WORD_W-1:0] mid);
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = {cur[WORD_W-1], nxt[WORD_W-2:0]};
        v = mid ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mersenne_twister_generator_core.sv =====
// Top level of the MT19937 random word generator: controller plus datapath.
// A request is accepted, its word is read from state memory, then loaded into the
// result register. Every 624 words a twist of the state comes first; when the state
// is unseeded (first request or restart) seeding and fill come before that twist.
// A new request waits for the result load; the read stalls while the output is full.
// Reset: synchronous active-low; seed returns to 4357 and the next request seeds.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] random_word
);
    import mtg_pkg::*;

    mtg_cmd_t    cmd;
    mtg_status_t status;

    mtg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .status   (status),
        .cmd      (cmd)
    );

    mtg_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_OUT) |-> !m_tvalid)
        else $error("result register loaded while still holding a request");

    a_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_FILL || cmd.op == CMD_TWIST || cmd.op == CMD_DRAW)
            |-> (cmd.addr <= LAST_IDX))
        else $error("state memory address out of range");

    a_draw_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_DRAW) |=> (cmd.op == CMD_OUT))
        else $error("draw read not followed by result load");

endmodule

`default_nettype wire

// ===== rtl/core/mtg_ctrl.sv =====
// Sequencer for seeding, twisting and drawing requests of the MT19937 core.
`timescale 1ns / 1ps
`default_nettype none

module mtg_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                restart,
    input  wire mtg_pkg::mtg_status_t status,
    output mtg_pkg::mtg_cmd_t        cmd
);
    import mtg_pkg::*;

    mtg_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= UNSEEDED_IDX;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        cmd.op     = CMD_NONE;
        cmd.addr   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (restart || idx_reg > FULL_IDX) begin
                        cmd.op     = CMD_SEED;
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end else if (idx_reg == FULL_IDX) begin
                        state_next = ST_PRIME;
                    end else begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_FILL: begin
                cmd.op   = CMD_FILL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    idx_next   = FULL_IDX;
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME: begin
                cmd.op     = CMD_PRIME;
                cnt_next   = '0;
                state_next = ST_TWIST;
            end
            ST_TWIST: begin
                cmd.op   = CMD_TWIST;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                cmd.addr = idx_reg;
                if (status.out_free) begin
                    cmd.op     = CMD_DRAW;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.op     = CMD_OUT;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mtg_datapath.sv =====
// State memory, seed recurrence, twist and tempering datapath of the MT19937 core.
`timescale 1ns / 1ps
`default_nettype none

module mtg_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [31:0]         cfg_wr_data,
    input  wire mtg_pkg::mtg_cmd_t   cmd,
    output mtg_pkg::mtg_status_t     status,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata
);
    import mtg_pkg::*;

    logic [WORD_W-1:0] mem [0:STATE_WORDS-1];

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] lcg_reg;
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;
    logic [WORD_W-1:0] cur_reg;
    logic              tw_wr_reg;
    logic [IDX_W-1:0]  tw_idx_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;

    logic [48:0]       lcg_prod;
    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  addr_a;
    logic [IDX_W-1:0]  addr_b;
    logic [WORD_W-1:0] twist_word;

    assign lcg_prod   = lcg_reg * LCG_MULT;
    assign mid_sum    = {1'b0, cmd.addr} + MID_STEP;
    assign addr_b     = (mid_sum >= WRAP_WORDS) ? IDX_W'(mid_sum - WRAP_WORDS)
                                                : mid_sum[IDX_W-1:0];
    assign twist_word = mtg_twist(cur_reg, rd_a_reg, rd_b_reg);

    always_comb begin
        case (cmd.op)
            CMD_PRIME: addr_a = '0;
            CMD_TWIST: addr_a = (cmd.addr == LAST_IDX) ? '0 : cmd.addr + 1'b1;
            default:   addr_a = cmd.addr;
        endcase
    end

    // memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_FILL) begin
            mem[cmd.addr] <= lcg_reg;
        end else if (tw_wr_reg) begin
            mem[tw_idx_reg] <= twist_word;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // cur_reg is read port A delayed by a register: old word k during the write of k
    always_ff @(posedge aclk) begin
        cur_reg    <= rd_a_reg;
        tw_idx_reg <= cmd.addr;
        if (cmd.op == CMD_SEED) begin
            lcg_reg <= seed_reg;
        end else if (cmd.op == CMD_FILL) begin
            lcg_reg <= lcg_prod[WORD_W-1:0];
        end
        if (cmd.op == CMD_OUT) begin
            out_data_reg <= mtg_temper(rd_a_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= DEFAULT_SEED;
            tw_wr_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            tw_wr_reg <= (cmd.op == CMD_TWIST);
            if (cmd.op == CMD_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

`default_nettype wire
